### hw/rtl/krd_pkg.sv
`default_nettype none

package krd_pkg;

    localparam int MAX_RECORDS = 64;
    localparam int IDX_W = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CNT_W = $clog2(MAX_RECORDS + 1);

    localparam int WORD_W = 32;
    localparam int MASK_W = 5;
    localparam int KIND_W = 2;
    localparam int IN_TDATA_W = 5 * WORD_W;
    localparam int OUT_TDATA_W = 40;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);

    localparam logic [MASK_W-1:0] MASK_TEXT = 5'b00001;
    localparam logic [MASK_W-1:0] MASK_ATTR = 5'b00010;
    localparam logic [MASK_W-1:0] MASK_OTHER = 5'b00100;
    localparam logic [MASK_W-1:0] MASK_ADDED = 5'b01000;
    localparam logic [MASK_W-1:0] MASK_REMOVED = 5'b10000;

    localparam logic [KIND_W-1:0] KIND_IGNORE = 2'd3;

    typedef enum logic [KIND_W-1:0] {
        OP_LOAD = 2'd0,
        OP_CMP = 2'd1,
        OP_END = 2'd2
    } op_t;

    typedef struct packed {
        op_t op;
        logic [WORD_W-1:0] id;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] text;
        logic [WORD_W-1:0] attr;
        logic [WORD_W-1:0] misc;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] key;
        logic [WORD_W-1:0] total;
        logic [WORD_W-1:0] text;
        logic [WORD_W-1:0] attr;
        logic [WORD_W-1:0] misc;
    } row_t;

endpackage

`default_nettype wire

### hw/rtl/keyed_record_diff_unit.sv
// Channel   Direction  Signals                           Carries
// s_axis    in         tvalid tready tdata tuser         one record item to load, compare, end or ignore
// m_axis    out        tvalid tready tdata tuser tlast   one result row
//
// A load passes the back end states ST_IDLE and ST_EXEC, and a compare that hits also ST_CMP;
// the shared lookup of all keys and the single read port of the record memory set these steps.
// An end item visits each stored entry in ST_SWRD, and each removed entry also in ST_SWWR,
// since the sweep reads the record memory one entry at a time; ST_FLUSH closes it.
// A two-item queue lets the input side keep taking items while the back end is busy.
// Reset is asynchronous and active low; the stored records need no clearing.
// Either side may stall at any time; the output register holds a row until it is taken.
`default_nettype none

module keyed_record_diff_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // record_id[31:0], total_count[63:32], text_count[95:64], attr_count[127:96],
    // misc_count[159:128]
    input  wire logic [krd_pkg::IN_TDATA_W-1:0]    s_tdata,
    // kind[1:0]
    input  wire logic [krd_pkg::KIND_W-1:0]        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // row_id[31:0], overflowed[32], zero[39:33]
    output logic [krd_pkg::OUT_TDATA_W-1:0]        m_tdata,
    // change_mask[4:0]
    output logic [krd_pkg::MASK_W-1:0]             m_tuser,
    output logic                                   m_tlast
);

    logic           push_valid;
    logic           push_ready;
    krd_pkg::item_t push_item;
    logic           pop_valid;
    logic           pop_ready;
    krd_pkg::item_t pop_item;

    krd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    krd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    krd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_item  (pop_item),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

### hw/rtl/krd_front.sv
`default_nettype none

module krd_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [krd_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  wire logic [krd_pkg::KIND_W-1:0]        s_tuser,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output krd_pkg::item_t                         push_item
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    krd_pkg::item_t hold_item_reg;
    krd_pkg::item_t hold_item_next;
    logic           accept;
    logic           keep;

    assign s_tready = !hold_valid_reg || push_ready;
    assign accept = s_tvalid && s_tready;
    assign keep = s_tuser != krd_pkg::KIND_IGNORE;

    always_comb
    begin
        hold_item_next.op = krd_pkg::op_t'(s_tuser);
        hold_item_next.id = s_tdata[31:0];
        hold_item_next.total = s_tdata[63:32];
        hold_item_next.text = s_tdata[95:64];
        hold_item_next.attr = s_tdata[127:96];
        hold_item_next.misc = s_tdata[159:128];
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (hold_valid_reg && push_ready)
        begin
            hold_valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            hold_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            hold_item_reg <= hold_item_next;
        end
    end

    assign push_valid = hold_valid_reg;
    assign push_item = hold_item_reg;

endmodule

`default_nettype wire

### hw/rtl/krd_queue.sv
`default_nettype none

module krd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push_valid,
    output logic                 push_ready,
    input  wire krd_pkg::item_t  push_item,
    output logic                 pop_valid,
    input  wire logic            pop_ready,
    output krd_pkg::item_t       pop_item
);

    krd_pkg::item_t                entries [krd_pkg::QUEUE_DEPTH];
    logic [krd_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [krd_pkg::QPTR_W-1:0]    wr_ptr_next;
    logic [krd_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [krd_pkg::QPTR_W-1:0]    rd_ptr_next;
    logic [krd_pkg::QPTR_W:0]      fill_reg;
    logic [krd_pkg::QPTR_W:0]      fill_next;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = fill_reg != (krd_pkg::QPTR_W + 1)'(krd_pkg::QUEUE_DEPTH);
    assign pop_valid = fill_reg != '0;
    assign pop_item = entries[rd_ptr_reg];
    assign do_push = push_valid && push_ready;
    assign do_pop = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next = fill_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/krd_back.sv
`default_nettype none

module krd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              pop_valid,
    output logic                                   pop_ready,
    input  wire krd_pkg::item_t                    pop_item,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [krd_pkg::OUT_TDATA_W-1:0]        m_tdata,
    output logic [krd_pkg::MASK_W-1:0]             m_tuser,
    output logic                                   m_tlast
);

    localparam int MAX = krd_pkg::MAX_RECORDS;
    localparam int IDX_W = krd_pkg::IDX_W;
    localparam int CNT_W = krd_pkg::CNT_W;
    localparam int WORD_W = krd_pkg::WORD_W;
    localparam int MASK_W = krd_pkg::MASK_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_CMP = 6'b000100,
        ST_SWRD = 6'b001000,
        ST_SWWR = 6'b010000,
        ST_FLUSH = 6'b100000
    } state_t;

    state_t               state_reg;
    state_t               state_next;
    krd_pkg::item_t       cur_reg;
    krd_pkg::item_t       cur_next;
    logic [MAX-1:0]       match_reg;
    logic [MAX-1:0]       match_next;
    logic [MAX-1:0]       matched_reg;
    logic [MAX-1:0]       matched_next;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 overflow_reg;
    logic                 overflow_next;
    logic [CNT_W-1:0]     sweep_reg;
    logic [CNT_W-1:0]     sweep_next;
    logic                 held_valid_reg;
    logic                 held_valid_next;
    logic [WORD_W-1:0]    held_id_reg;
    logic [WORD_W-1:0]    held_id_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [WORD_W-1:0]    out_id_reg;
    logic [WORD_W-1:0]    out_id_next;
    logic [MASK_W-1:0]    out_mask_reg;
    logic [MASK_W-1:0]    out_mask_next;
    logic                 out_last_reg;
    logic                 out_last_next;
    logic                 out_ovf_reg;
    logic                 out_ovf_next;

    logic [WORD_W-1:0]    key_reg [MAX];
    logic                 key_we;
    logic [IDX_W-1:0]     key_wa;

    krd_pkg::row_t        mem [MAX];
    krd_pkg::row_t        rd_data_reg;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_wa;
    krd_pkg::row_t        mem_wd;
    logic                 mem_re;
    logic [IDX_W-1:0]     mem_ra;

    logic [MAX-1:0]       match_now;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic                 full;
    logic                 out_free;
    logic [IDX_W-1:0]     sweep_idx;
    logic [IDX_W-1:0]     count_idx;
    logic [MASK_W-1:0]    diff_mask;
    logic                 emit;
    logic [WORD_W-1:0]    emit_id;
    logic [MASK_W-1:0]    emit_mask;
    logic                 emit_last;

    always_comb
    begin
        for (int i = 0; i < MAX; i++)
        begin
            match_now[i] = (key_reg[i] == pop_item.id) && (CNT_W'(i) < count_reg);
        end
    end

    always_comb
    begin
        hit_idx = '0;
        for (int i = 0; i < MAX; i++)
        begin
            if (match_reg[i])
            begin
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    assign hit = |match_reg;
    assign full = count_reg == CNT_W'(MAX);
    assign out_free = !out_valid_reg || m_tready;
    assign sweep_idx = sweep_reg[IDX_W-1:0];
    assign count_idx = count_reg[IDX_W-1:0];

    always_comb
    begin
        diff_mask = '0;
        if (rd_data_reg.text != cur_reg.text)
        begin
            diff_mask = diff_mask | krd_pkg::MASK_TEXT;
        end
        if (rd_data_reg.attr != cur_reg.attr)
        begin
            diff_mask = diff_mask | krd_pkg::MASK_ATTR;
        end
        if (rd_data_reg.misc != cur_reg.misc)
        begin
            diff_mask = diff_mask | krd_pkg::MASK_OTHER;
        end
        if (diff_mask == '0)
        begin
            diff_mask = krd_pkg::MASK_OTHER;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cur_next = cur_reg;
        match_next = match_reg;
        matched_next = matched_reg;
        count_next = count_reg;
        overflow_next = overflow_reg;
        sweep_next = sweep_reg;
        held_valid_next = held_valid_reg;
        held_id_next = held_id_reg;
        pop_ready = 1'b0;
        key_we = 1'b0;
        key_wa = count_idx;
        mem_we = 1'b0;
        mem_wa = count_idx;
        mem_wd.key = cur_reg.id;
        mem_wd.total = cur_reg.total;
        mem_wd.text = cur_reg.text;
        mem_wd.attr = cur_reg.attr;
        mem_wd.misc = cur_reg.misc;
        mem_re = 1'b0;
        mem_ra = sweep_idx;
        emit = 1'b0;
        emit_id = cur_reg.id;
        emit_mask = krd_pkg::MASK_ADDED;
        emit_last = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    pop_ready = 1'b1;
                    cur_next = pop_item;
                    match_next = match_now;
                    if (pop_item.op == krd_pkg::OP_END)
                    begin
                        sweep_next = '0;
                        held_valid_next = 1'b0;
                        state_next = ST_SWRD;
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end
            ST_EXEC:
            begin
                if (cur_reg.op == krd_pkg::OP_LOAD)
                begin
                    state_next = ST_IDLE;
                    if (hit)
                    begin
                        mem_we = 1'b1;
                        mem_wa = hit_idx;
                    end
                    else if (full)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        key_we = 1'b1;
                        matched_next[count_idx] = 1'b0;
                        count_next = count_reg + 1'b1;
                    end
                end
                else if (hit)
                begin
                    matched_next[hit_idx] = 1'b1;
                    mem_re = 1'b1;
                    mem_ra = hit_idx;
                    state_next = ST_CMP;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_CMP:
            begin
                if (rd_data_reg.total == cur_reg.total)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    emit = 1'b1;
                    emit_mask = diff_mask;
                    state_next = ST_IDLE;
                end
            end
            ST_SWRD:
            begin
                if (sweep_reg == count_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else if (!matched_reg[sweep_idx])
                begin
                    mem_re = 1'b1;
                    state_next = ST_SWWR;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            ST_SWWR:
            begin
                if (!held_valid_reg || out_free)
                begin
                    emit = held_valid_reg;
                    emit_id = held_id_reg;
                    emit_mask = krd_pkg::MASK_REMOVED;
                    held_id_next = rd_data_reg.key;
                    held_valid_next = 1'b1;
                    sweep_next = sweep_reg + 1'b1;
                    state_next = ST_SWRD;
                end
            end
            ST_FLUSH:
            begin
                if (!held_valid_reg || out_free)
                begin
                    emit = held_valid_reg;
                    emit_id = held_id_reg;
                    emit_mask = krd_pkg::MASK_REMOVED;
                    emit_last = 1'b1;
                    held_valid_next = 1'b0;
                    count_next = '0;
                    matched_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !m_tready;
        out_id_next = out_id_reg;
        out_mask_next = out_mask_reg;
        out_last_next = out_last_reg;
        out_ovf_next = out_ovf_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            out_id_next = emit_id;
            out_mask_next = emit_mask;
            out_last_next = emit_last;
            out_ovf_next = overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            matched_reg <= '0;
            count_reg <= '0;
            overflow_reg <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            matched_reg <= matched_next;
            count_reg <= count_next;
            overflow_reg <= overflow_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        match_reg <= match_next;
        sweep_reg <= sweep_next;
        held_id_reg <= held_id_next;
        out_id_reg <= out_id_next;
        out_mask_reg <= out_mask_next;
        out_last_reg <= out_last_next;
        out_ovf_reg <= out_ovf_next;
        if (key_we)
        begin
            key_reg[key_wa] <= cur_reg.id;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = {(krd_pkg::OUT_TDATA_W - WORD_W - 1)'(0), out_ovf_reg, out_id_reg};
    assign m_tuser = out_mask_reg;
    assign m_tlast = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/krd_checker.sv
`default_nettype none

module krd_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [krd_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input wire logic [krd_pkg::MASK_W-1:0]        m_tuser,
    input wire logic                              m_tlast
);

    // A final row of a sweep is always a removed row.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == krd_pkg::MASK_REMOVED)
    else $error("last row is not a removed row");

    // Added and changed rows never close a sweep.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != krd_pkg::MASK_REMOVED |-> !m_tlast)
    else $error("non-removed row marked last");

    // A removed row carries no other change bit, an added row no sub-counter bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser & (krd_pkg::MASK_REMOVED | krd_pkg::MASK_ADDED)) != '0
            |-> $countones(m_tuser) == 1)
    else $error("removed or added row mixed with other change bits");

    // A stalled row holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output row changed while stalled");

endmodule

bind keyed_record_diff_unit krd_checker u_krd_checker (.*);

`default_nettype wire

### verif/keyed_record_diff_checker.sv
module keyed_record_diff_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    input  wire logic                            s_tready,
    input  wire logic [krd_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic [krd_pkg::KIND_W-1:0]      s_tuser,
    input  wire logic                            m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [krd_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  wire logic [krd_pkg::MASK_W-1:0]      m_tuser,
    input  wire logic                            m_tlast,
    output int                                   mismatch_count,
    output int                                   rows_outstanding
);

    typedef struct {
        logic [krd_pkg::WORD_W-1:0] id;
        logic [krd_pkg::MASK_W-1:0] mask;
        logic                       last;
        logic                       overflowed;
    } diff_row_t;

    logic [krd_pkg::WORD_W-1:0] tbl_key     [krd_pkg::MAX_RECORDS];
    logic [krd_pkg::WORD_W-1:0] tbl_total   [krd_pkg::MAX_RECORDS];
    logic [krd_pkg::WORD_W-1:0] tbl_text    [krd_pkg::MAX_RECORDS];
    logic [krd_pkg::WORD_W-1:0] tbl_attr    [krd_pkg::MAX_RECORDS];
    logic [krd_pkg::WORD_W-1:0] tbl_misc    [krd_pkg::MAX_RECORDS];
    logic                       tbl_matched [krd_pkg::MAX_RECORDS];
    int                         tbl_used;
    logic                       sticky_overflow;
    diff_row_t                  expected_rows [$];

    initial mismatch_count = 0;

    task automatic report_mismatch(input string what);
        if (mismatch_count < 200)
            $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int find_slot(input logic [krd_pkg::WORD_W-1:0] key);
        for (int i = 0; i < tbl_used; i++)
            if (tbl_key[i] == key)
                return i;
        return krd_pkg::MAX_RECORDS;
    endfunction

    task automatic push_row(input logic [krd_pkg::WORD_W-1:0] id,
                            input logic [krd_pkg::MASK_W-1:0] mask,
                            input logic last);
        diff_row_t row;
        row.id = id;
        row.mask = mask;
        row.last = last;
        row.overflowed = sticky_overflow;
        expected_rows.insert(expected_rows.size(), row);
    endtask

    task automatic predict_record(input logic [krd_pkg::KIND_W-1:0] kind,
                                  input logic [krd_pkg::IN_TDATA_W-1:0] data);
        logic [krd_pkg::WORD_W-1:0] id;
        logic [krd_pkg::WORD_W-1:0] total;
        logic [krd_pkg::WORD_W-1:0] text;
        logic [krd_pkg::WORD_W-1:0] attr;
        logic [krd_pkg::WORD_W-1:0] misc;
        logic [krd_pkg::MASK_W-1:0] mask;
        int slot;
        int unmatched;
        int seen;
        id = data[krd_pkg::WORD_W-1:0];
        total = data[2*krd_pkg::WORD_W-1:krd_pkg::WORD_W];
        text = data[3*krd_pkg::WORD_W-1:2*krd_pkg::WORD_W];
        attr = data[4*krd_pkg::WORD_W-1:3*krd_pkg::WORD_W];
        misc = data[5*krd_pkg::WORD_W-1:4*krd_pkg::WORD_W];
        slot = find_slot(id);
        case (kind)
            krd_pkg::OP_LOAD:
            begin
                if (slot == krd_pkg::MAX_RECORDS && tbl_used == krd_pkg::MAX_RECORDS)
                    sticky_overflow = 1'b1;
                else
                begin
                    if (slot == krd_pkg::MAX_RECORDS)
                    begin
                        slot = tbl_used;
                        tbl_used++;
                        tbl_key[slot] = id;
                        tbl_matched[slot] = 1'b0;
                    end
                    tbl_total[slot] = total;
                    tbl_text[slot] = text;
                    tbl_attr[slot] = attr;
                    tbl_misc[slot] = misc;
                end
            end
            krd_pkg::OP_CMP:
            begin
                if (slot == krd_pkg::MAX_RECORDS)
                    push_row(id, krd_pkg::MASK_ADDED, 1'b0);
                else
                begin
                    tbl_matched[slot] = 1'b1;
                    if (tbl_total[slot] != total)
                    begin
                        mask = '0;
                        if (tbl_text[slot] != text)
                            mask |= krd_pkg::MASK_TEXT;
                        if (tbl_attr[slot] != attr)
                            mask |= krd_pkg::MASK_ATTR;
                        if (tbl_misc[slot] != misc)
                            mask |= krd_pkg::MASK_OTHER;
                        if (mask == '0)
                            mask = krd_pkg::MASK_OTHER;
                        push_row(id, mask, 1'b0);
                    end
                end
            end
            krd_pkg::OP_END:
            begin
                unmatched = 0;
                for (int i = 0; i < tbl_used; i++)
                    if (!tbl_matched[i])
                        unmatched++;
                seen = 0;
                for (int i = 0; i < tbl_used; i++)
                begin
                    if (!tbl_matched[i])
                    begin
                        seen++;
                        push_row(tbl_key[i], krd_pkg::MASK_REMOVED, seen == unmatched);
                    end
                end
                for (int i = 0; i < krd_pkg::MAX_RECORDS; i++)
                    tbl_matched[i] = 1'b0;
                tbl_used = 0;
            end
            default: ;
        endcase
    endtask

    task automatic check_row();
        diff_row_t want;
        if (expected_rows.size() == 0)
            report_mismatch($sformatf("unexpected row id %h mask %b last %b",
                                      m_tdata[krd_pkg::WORD_W-1:0], m_tuser, m_tlast));
        else
        begin
            want = expected_rows.pop_front();
            if (m_tdata[krd_pkg::WORD_W-1:0] !== want.id)
                report_mismatch($sformatf("row_id %h, expected %h",
                                          m_tdata[krd_pkg::WORD_W-1:0], want.id));
            if (m_tuser !== want.mask)
                report_mismatch($sformatf("change_mask %b, expected %b for id %h",
                                          m_tuser, want.mask, want.id));
            if (m_tlast !== want.last)
                report_mismatch($sformatf("last_row %b, expected %b for id %h",
                                          m_tlast, want.last, want.id));
            if (m_tdata[krd_pkg::WORD_W] !== want.overflowed)
                report_mismatch($sformatf("overflowed %b, expected %b for id %h",
                                          m_tdata[krd_pkg::WORD_W], want.overflowed,
                                          want.id));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_used = 0;
            sticky_overflow = 1'b0;
            for (int i = 0; i < krd_pkg::MAX_RECORDS; i++)
                tbl_matched[i] = 1'b0;
            expected_rows.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_row();
            if (s_tvalid && s_tready)
                predict_record(s_tuser, s_tdata);
        end
        rows_outstanding = expected_rows.size();
    end

endmodule

### verif/keyed_record_diff_unit_tb.sv
module keyed_record_diff_unit_tb;

    localparam int IDLE_PCT = 24;
    localparam int HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [krd_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic [krd_pkg::KIND_W-1:0]      s_tuser = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [krd_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic [krd_pkg::MASK_W-1:0]      m_tuser;
    logic                            m_tlast;

    int mismatch_count;
    int rows_outstanding;
    int items_sent = 0;
    int quiet_cycles = 0;
    bit no_idle = 1'b0;
    bit hold_request = 1'b0;
    bit hold_done = 1'b0;

    logic [krd_pkg::WORD_W-1:0] src_ids [$];
    logic [krd_pkg::WORD_W-1:0] src_tot [$];
    logic [krd_pkg::WORD_W-1:0] src_txt [$];
    logic [krd_pkg::WORD_W-1:0] src_atr [$];
    logic [krd_pkg::WORD_W-1:0] src_msc [$];

    keyed_record_diff_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    keyed_record_diff_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tuser          (s_tuser),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .mismatch_count   (mismatch_count),
        .rows_outstanding (rows_outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
                m_tready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic logic [krd_pkg::WORD_W-1:0] rand_word();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return $urandom_range(15);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [krd_pkg::WORD_W-1:0] other_word(
        input logic [krd_pkg::WORD_W-1:0] w);
        case ($urandom_range(2))
            0: return ~w;
            1: return w + 1'b1;
            default: return w ^ ($urandom | 32'h1);
        endcase
    endfunction

    function automatic int session_loads();
        return ($urandom_range(4) == 0) ? $urandom_range(30, 12) : $urandom_range(10);
    endfunction

    task automatic send_item(input logic [krd_pkg::KIND_W-1:0] kind,
                             input logic [krd_pkg::WORD_W-1:0] id, tot, txt, atr, msc);
        @(negedge clk);
        while (!no_idle && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {msc, atr, txt, tot, id};
        do
            @(posedge clk);
        while (!s_tready);
        if (kind != krd_pkg::KIND_IGNORE)
            items_sent++;
    endtask

    task automatic load_rec(input logic [krd_pkg::WORD_W-1:0] id, tot, txt, atr, msc);
        int slot;
        slot = -1;
        foreach (src_ids[i])
            if (src_ids[i] == id)
                slot = i;
        send_item(krd_pkg::OP_LOAD, id, tot, txt, atr, msc);
        if (slot >= 0)
        begin
            src_tot[slot] = tot;
            src_txt[slot] = txt;
            src_atr[slot] = atr;
            src_msc[slot] = msc;
        end
        else if (src_ids.size() < krd_pkg::MAX_RECORDS)
        begin
            src_ids.insert(src_ids.size(), id);
            src_tot.insert(src_tot.size(), tot);
            src_txt.insert(src_txt.size(), txt);
            src_atr.insert(src_atr.size(), atr);
            src_msc.insert(src_msc.size(), msc);
        end
    endtask

    task automatic end_table();
        send_item(krd_pkg::OP_END, $urandom, $urandom, $urandom, $urandom, $urandom);
        src_ids.delete();
        src_tot.delete();
        src_txt.delete();
        src_atr.delete();
        src_msc.delete();
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (rows_outstanding != 0)
            @(negedge clk);
    endtask

    task automatic run_session(input int n_loads, input int n_targets, input bit closing);
        int i;
        int pick;
        logic [krd_pkg::WORD_W-1:0] id;
        logic [krd_pkg::WORD_W-1:0] tot;
        logic [krd_pkg::WORD_W-1:0] txt;
        logic [krd_pkg::WORD_W-1:0] atr;
        logic [krd_pkg::WORD_W-1:0] msc;
        if (n_loads > 0 && src_ids.size() + n_loads > krd_pkg::MAX_RECORDS - 4)
            end_table();
        for (i = 0; i < n_loads; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(krd_pkg::KIND_IGNORE, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            if (src_ids.size() > 0 && $urandom_range(9) == 0)
                id = src_ids[$urandom_range(src_ids.size() - 1)];
            else
                id = $urandom;
            load_rec(id, rand_word(), rand_word(), rand_word(), rand_word());
        end
        for (i = 0; i < n_targets; i++)
        begin
            if ($urandom_range(19) == 0)
                send_item(krd_pkg::KIND_IGNORE, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            if (src_ids.size() == 0 || $urandom_range(6) == 0)
                send_item(krd_pkg::OP_CMP, $urandom, rand_word(), rand_word(), rand_word(),
                          rand_word());
            else
            begin
                pick = $urandom_range(src_ids.size() - 1);
                tot = ($urandom_range(3) == 0) ? src_tot[pick] : other_word(src_tot[pick]);
                txt = $urandom_range(1) ? src_txt[pick] : other_word(src_txt[pick]);
                atr = $urandom_range(1) ? src_atr[pick] : other_word(src_atr[pick]);
                msc = $urandom_range(1) ? src_msc[pick] : other_word(src_msc[pick]);
                send_item(krd_pkg::OP_CMP, src_ids[pick], tot, txt, atr, msc);
            end
        end
        if (closing)
            end_table();
    endtask

    initial
    begin
        int i;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Sweep of an empty table, then a lookup that can only miss.
        send_item(krd_pkg::OP_END, '0, '0, '0, '0, '0);
        send_item(krd_pkg::OP_CMP, 32'h0, '0, '0, '0, '0);
        load_rec(32'h0, '0, '0, '0, '0);
        load_rec(32'hFFFF_FFFF, '1, '1, '1, '1);
        load_rec(32'h5, 32'd1, 32'd2, 32'd3, 32'd4);
        load_rec(32'h5, 32'd10, 32'd20, 32'd30, 32'd40);
        load_rec(32'h7, 32'd100, 32'd200, 32'd300, 32'd400);
        load_rec(32'h9, 32'd9, 32'd9, 32'd9, 32'd9);
        load_rec(32'h8000_0000, '1, '0, '1, '0);
        // Equal totals still mark the entry as matched.
        send_item(krd_pkg::OP_CMP, 32'h0, '0, '1, '1, '1);
        send_item(krd_pkg::OP_CMP, 32'hFFFF_FFFF, '0, '1, '0, '1);
        send_item(krd_pkg::OP_CMP, 32'h5, 32'd11, 32'd20, 32'd30, 32'd40);
        send_item(krd_pkg::OP_CMP, 32'h7, '0, '0, '0, '0);
        send_item(krd_pkg::KIND_IGNORE, 32'h9, 32'd1, 32'd1, 32'd1, 32'd1);
        send_item(krd_pkg::OP_CMP, 32'hDEAD_BEEF, '1, '1, '1, '1);
        send_item(krd_pkg::OP_CMP, 32'h7, 32'd100, '0, '0, '0);
        end_table();
        // A reload of a matched key keeps its matched bit, so only the new key is removed.
        load_rec(32'h5, 32'd3, 32'd3, 32'd3, 32'd3);
        send_item(krd_pkg::OP_CMP, 32'h5, 32'd3, 32'd0, 32'd0, 32'd0);
        load_rec(32'h5, 32'd4, 32'd4, 32'd4, 32'd4);
        load_rec(32'h6, 32'd6, 32'd6, 32'd6, 32'd6);
        end_table();
        load_rec(32'h5, 32'd1, 32'd1, 32'd1, 32'd1);
        send_item(krd_pkg::OP_CMP, 32'h5, 32'd1, 32'd1, 32'd1, 32'd1);
        end_table();
        send_item(krd_pkg::OP_CMP, 32'h5, 32'd1, 32'd1, 32'd1, 32'd1);

        while (items_sent < 200)
            run_session(session_loads(), $urandom_range(12), $urandom_range(9) != 0);
        wait_drained();

        no_idle = 1'b1;
        while (items_sent < 280)
            run_session(session_loads(), $urandom_range(12), $urandom_range(9) != 0);
        no_idle = 1'b0;

        // Fill the table, overflow it, then sweep it while the output is held off.
        if (src_ids.size() != 0)
            end_table();
        for (i = 0; i < krd_pkg::MAX_RECORDS; i++)
            load_rec($urandom, rand_word(), rand_word(), rand_word(), rand_word());
        load_rec($urandom, rand_word(), rand_word(), rand_word(), rand_word());
        load_rec($urandom, rand_word(), rand_word(), rand_word(), rand_word());
        load_rec(src_ids[0], rand_word(), rand_word(), rand_word(), rand_word());
        run_session(0, 10, 1'b0);
        hold_request = 1'b1;
        end_table();
        for (i = 0; i < 12; i++)
            send_item(krd_pkg::OP_CMP, $urandom, rand_word(), rand_word(), rand_word(),
                      rand_word());
        wait_drained();

        while (items_sent < 450)
            run_session(session_loads(), $urandom_range(12), $urandom_range(9) != 0);
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### keyed_record_diff_unit.f
hw/rtl/krd_pkg.sv
hw/rtl/krd_front.sv
hw/rtl/krd_queue.sv
hw/rtl/krd_back.sv
hw/rtl/keyed_record_diff_unit.sv
hw/rtl/krd_checker.sv
verif/keyed_record_diff_checker.sv
verif/keyed_record_diff_unit_tb.sv
